// File: hdl/mwse_pkg.sv
// Shared constants and types for the minimum window sum unit.
package mwse_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int VALUE_BITS = 16;

  localparam int IDX_W    = $clog2(MAX_WINDOW);
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = VALUE_BITS + $clog2(MAX_WINDOW);
  localparam int THRESH_W = 26;
  localparam int CMP_W    = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam int LEN_W    = 11;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int REG_THRESHOLD = 0;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } item_t;

endpackage

// File: hdl/mwse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: hdl/mwse_front.sv
// Input side: accepts words and holds them in a short queue for the engine.
module mwse_front
  import mwse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_last,
  output logic                  q_valid,
  output item_t                 q_item,
  input  logic                  q_pop
);

  item_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entry_r[rptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= '{value: in_value, last: in_last};
    end
  end

endmodule

// File: hdl/mwse_back.sv
// Window engine: appends values, shrinks the window and builds the result.
module mwse_back
  import mwse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [THRESH_W-1:0] threshold,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEN_W-1:0]    out_min_length,
  output logic                out_found,
  output logic                out_overflow
);

  typedef enum logic [3:0] {
    S_TAKE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SUB   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   best_len_r, best_len_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_found_r, out_ovf_r;
  logic               load_out;
  logic               ram_we, ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic               over;

  assign over = (CMP_W'(sum_r) > CMP_W'(threshold)) && (count_r != '0);

  mwse_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (head_r),
    .wdata   (q_item.value),
    .re      (ram_re),
    .raddr   (tail_r),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    best_len_nxt   = best_len_r;
    best_valid_nxt = best_valid_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    load_out       = 1'b0;
    unique case (state_r)
      S_TAKE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          last_nxt = q_item.last;
          if (count_r == CNT_W'(MAX_WINDOW)) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            head_nxt  = (head_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + SUM_W'(q_item.value);
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (over) begin
          if (!best_valid_r || count_r < best_len_r) begin
            best_len_nxt   = count_r;
            best_valid_nxt = 1'b1;
          end
          ram_re    = 1'b1;
          state_nxt = S_SUB;
        end else if (last_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_SUB: begin
        sum_nxt   = sum_r - SUM_W'(ram_rdata);
        tail_nxt  = (tail_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : tail_r + 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = S_CHECK;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out       = 1'b1;
          head_nxt       = '0;
          tail_nxt       = '0;
          count_nxt      = '0;
          sum_nxt        = '0;
          best_len_nxt   = '0;
          best_valid_nxt = 1'b0;
          ovf_nxt        = 1'b0;
          last_nxt       = 1'b0;
          state_nxt      = S_TAKE;
        end
      end
      default: begin
        state_nxt = S_TAKE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_TAKE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      best_len_r   <= '0;
      best_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      best_len_r   <= best_len_nxt;
      best_valid_r <= best_valid_nxt;
      ovf_r        <= ovf_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_len_r   <= best_valid_r ? LEN_W'(best_len_r) : '0;
      out_found_r <= best_valid_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_min_length = out_len_r;
  assign out_found      = out_found_r;
  assign out_overflow   = out_ovf_r;

endmodule

// File: hdl/min_window_sum_exceeds_unit.sv
// Top level of the unit that finds the shortest window whose sum exceeds a threshold.
// Each input word passes the engine's take and check states, plus a subtract and a check
// state for every value that leaves the window, plus an emit state to hand over the
// result on a word marked last; the engine's single RAM read port fetches one old value
// per drop. A two-word queue sits in front of the engine, so the input side takes words
// while the engine works or a result waits, until the queue is full. The window RAM has
// no reset pass: only entries that were written are ever read. The threshold register
// sits at byte address 0 and should be written while the unit is idle.
module min_window_sum_exceeds_unit
  import mwse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEN_W-1:0]      out_min_length,
  output logic                  out_found,
  output logic                  out_overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [THRESH_W-1:0] threshold_r;
  logic                reg_sel;
  logic                q_valid;
  item_t               q_item;
  logic                q_pop;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W - 2)'(REG_THRESHOLD));
  assign prdata  = reg_sel ? CFG_DATA_W'(threshold_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      threshold_r <= pwdata[THRESH_W-1:0];
    end
  end

  mwse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mwse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (threshold_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_min_length (out_min_length),
    .out_found      (out_found),
    .out_overflow   (out_overflow)
  );

endmodule

// File: hdl/mwse_checker.sv
// Port-level checker for the minimum window sum unit, bound to the top level.
module mwse_checker
  import mwse_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LEN_W-1:0]      out_min_length,
  input logic                  out_found,
  input logic                  out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_length) && $stable(out_found)
      && $stable(out_overflow))
    else $error("Stalled result word changed or vanished.");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_min_length == '0)
    else $error("Length is nonzero although no window was found.");

  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_min_length != '0
      && out_min_length <= LEN_W'(MAX_WINDOW))
    else $error("Found length outside one to the window capacity.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

endmodule

bind min_window_sum_exceeds_unit mwse_checker u_mwse_checker (.*);
